// ===== design/orb_pkg.sv =====
// Shared types and constants for the overwriting ring buffer.
// Used by the channel interfaces and every module of the block but orb_ram; no dependencies.
package orb_pkg;

   // Request kinds carried in req_type.
   localparam logic [1:0] REQ_PUSH = 2'd0;
   localparam logic [1:0] REQ_POP  = 2'd1;
   localparam logic [1:0] REQ_PEEK = 2'd2;

   // Fixed widths of the channel fields.
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 4;

   // Command queue between the front and the back.
   localparam int QDEPTH  = 4;
   localparam int Q_PTR_W = $clog2(QDEPTH);
   localparam int Q_LVL_W = $clog2(QDEPTH + 1);

   // Classification of one request, held while the registered memory read completes.
   typedef struct packed {
      logic               do_read;
      logic               underflow;
      logic               overwrote_oldest;
      logic [COUNT_W-1:0] item_count;
      logic               is_empty;
      logic               is_full;
   } meta_type;

   // Finished result word as it waits in the queue.
   typedef struct packed {
      logic [DATA_W-1:0]  read_value;
      logic               underflow;
      logic               overwrote_oldest;
      logic [COUNT_W-1:0] item_count;
      logic               is_empty;
      logic               is_full;
   } cmd_type;

   // Enqueue request from the front to the back.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } enq_type;

endpackage

// ===== design/orb_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on orb_pkg for the field widths.
interface orb_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 req_type;
   logic [orb_pkg::DATA_W-1:0] push_value;

   modport source (output valid, req_type, push_value, input ready);
   modport sink   (input valid, req_type, push_value, output ready);
endinterface

interface orb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [orb_pkg::DATA_W-1:0]  read_value;
   logic                        underflow;
   logic                        overwrote_oldest;
   logic [orb_pkg::COUNT_W-1:0] item_count;
   logic                        is_empty;
   logic                        is_full;

   modport source (output valid, read_value, underflow, overwrote_oldest, item_count,
                   is_empty, is_full, input ready);
   modport sink   (input valid, read_value, underflow, overwrote_oldest, item_count,
                   is_empty, is_full, output ready);
endinterface

// ===== design/orb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module orb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/orb_front.sv =====
// Front of the ring buffer: accepts requests, keeps the pointers and the count,
// drives the entry RAM and hands classified result words to the back.
// Depends on orb_pkg and orb_req_if.
module orb_front #(
   parameter int DEPTH = 8,
   parameter int WORD_WIDTH = 32,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   orb_req_if.sink                       req_ch,
   input  logic [orb_pkg::Q_LVL_W-1:0]   q_level,
   output orb_pkg::enq_type              enq,
   output logic                          ram_wr_en,
   output logic [PTR_W-1:0]              ram_wr_addr,
   output logic [WORD_WIDTH-1:0]         ram_wr_data,
   output logic                          ram_rd_en,
   output logic [PTR_W-1:0]              ram_rd_addr,
   input  logic [WORD_WIDTH-1:0]         ram_rd_data
);

   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] op_ff, op_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             s1_valid_ff, s1_valid_in;
   orb_pkg::meta_type s1_meta_ff, s1_meta_in;

   logic             accept;
   logic [PTR_W-1:0] next_wp;
   logic [PTR_W-1:0] next_op;
   logic             is_full_now;
   logic [orb_pkg::Q_LVL_W-1:0] pending;

   // A request is taken only when the queue has a slot for it and for the
   // word still waiting on the RAM read.
   assign pending      = q_level + orb_pkg::Q_LVL_W'(s1_valid_ff);
   assign req_ch.ready = !reset && (pending < orb_pkg::Q_LVL_W'(orb_pkg::QDEPTH));
   assign accept       = req_ch.valid && req_ch.ready;

   // Pointer increments with wrap at the buffer depth.
   assign next_wp = (wp_ff == PTR_W'(DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
   assign next_op = (op_ff == PTR_W'(DEPTH - 1)) ? '0 : op_ff + PTR_W'(1);
   assign is_full_now = (count_ff == CNT_W'(DEPTH));

   // Classify the request and compute the new pointers and count.
   always_comb begin
      wp_in      = wp_ff;
      op_in      = op_ff;
      count_in   = count_ff;
      ram_wr_en  = 1'b0;
      ram_rd_en  = 1'b0;
      s1_meta_in = '0;
      if (accept) begin
         unique case (req_ch.req_type) inside
            orb_pkg::REQ_PUSH: begin
               ram_wr_en = 1'b1;
               wp_in     = next_wp;
               if (!is_full_now) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  op_in = next_op;
                  s1_meta_in.overwrote_oldest = 1'b1;
               end
            end
            orb_pkg::REQ_POP, orb_pkg::REQ_PEEK: begin
               if (count_ff == '0) begin
                  s1_meta_in.underflow = 1'b1;
               end else begin
                  ram_rd_en          = 1'b1;
                  s1_meta_in.do_read = 1'b1;
                  if (req_ch.req_type == orb_pkg::REQ_POP) begin
                     op_in    = next_op;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
               // Unknown kinds leave the state alone and report it.
            end
         endcase
         s1_meta_in.item_count = orb_pkg::COUNT_W'(count_in);
         s1_meta_in.is_empty   = (count_in == '0);
         s1_meta_in.is_full    = (count_in == CNT_W'(DEPTH));
      end
   end

   assign s1_valid_in = accept;
   assign ram_wr_addr = wp_ff;
   assign ram_wr_data = WORD_WIDTH'(req_ch.push_value);
   assign ram_rd_addr = op_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         op_ff       <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         op_ff       <= op_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Classification is registered alongside the registered RAM read.
   always_ff @(posedge clock) begin
      s1_meta_ff <= s1_meta_in;
   end

   // Join the read data with the classification and enqueue the word.
   always_comb begin
      enq.valid                = s1_valid_ff;
      enq.cmd.read_value       = s1_meta_ff.do_read ? orb_pkg::DATA_W'(ram_rd_data) : '0;
      enq.cmd.underflow        = s1_meta_ff.underflow;
      enq.cmd.overwrote_oldest = s1_meta_ff.overwrote_oldest;
      enq.cmd.item_count       = s1_meta_ff.item_count;
      enq.cmd.is_empty         = s1_meta_ff.is_empty;
      enq.cmd.is_full          = s1_meta_ff.is_full;
   end

`ifndef SYNTH
   // The count never goes past the buffer depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("held count exceeds depth");

   // An empty or full buffer has its pointers in the same place.
   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(DEPTH)) |-> (wp_ff == op_ff))
      else $error("pointers disagree with the count");

   // A word leaving the read stage always finds room in the queue.
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (q_level != orb_pkg::Q_LVL_W'(orb_pkg::QDEPTH)))
      else $error("enqueue into a full queue");
`endif

endmodule

// ===== design/orb_back.sv =====
// Back of the ring buffer: a short result queue and the response output register.
// Depends on orb_pkg and orb_rsp_if.
module orb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  orb_pkg::enq_type            enq,
   output logic [orb_pkg::Q_LVL_W-1:0] q_level,
   orb_rsp_if.source                   rsp_ch
);

   orb_pkg::cmd_type q_mem_ff [orb_pkg::QDEPTH];
   logic [orb_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [orb_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [orb_pkg::Q_LVL_W-1:0] level_ff, level_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   orb_pkg::cmd_type            rsp_data_ff, rsp_data_in;
   logic                        pop;

   // Move a word to the output register whenever it is empty or being taken.
   assign pop = (level_ff != '0) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      wr_ptr_in    = enq.valid ? wr_ptr_ff + orb_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + orb_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      level_in     = level_ff + orb_pkg::Q_LVL_W'(enq.valid) - orb_pkg::Q_LVL_W'(pop);
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_ch.ready);
      rsp_data_in  = pop ? q_mem_ff[rd_ptr_ff] : rsp_data_ff;
   end

   // Queue and output control.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Queue storage and output payload.
   always_ff @(posedge clock) begin
      if (enq.valid) begin
         q_mem_ff[wr_ptr_ff] <= enq.cmd;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign q_level                 = level_ff;
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.read_value       = rsp_data_ff.read_value;
   assign rsp_ch.underflow        = rsp_data_ff.underflow;
   assign rsp_ch.overwrote_oldest = rsp_data_ff.overwrote_oldest;
   assign rsp_ch.item_count       = rsp_data_ff.item_count;
   assign rsp_ch.is_empty         = rsp_data_ff.is_empty;
   assign rsp_ch.is_full          = rsp_data_ff.is_full;

`ifndef SYNTH
   // The queue level stays within its depth.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= orb_pkg::Q_LVL_W'(orb_pkg::QDEPTH))
      else $error("queue level exceeds depth");

   // A full queue implies the output register is occupied.
   a_full_means_busy: assert property (@(posedge clock) disable iff (reset)
      (level_ff == orb_pkg::Q_LVL_W'(orb_pkg::QDEPTH)) |-> rsp_valid_ff)
      else $error("queue full while output register is idle");
`endif

endmodule

// ===== design/overwriting_ring_buffer_top.sv =====
// Overwriting ring buffer: each request word gives one response word.
// Path: a request is classified with the registered RAM read, then enqueued and moved to the response output register.
// Throughput: one request per cycle while responses are taken; the registered RAM
// read and a four-word result queue set the pipeline, so there is no stall of its own.
// Reset: synchronous, clears pointers, count and queue; stored words are not cleared.
// Depends on orb_pkg, orb_if, orb_ram, orb_front and orb_back.
module overwriting_ring_buffer_top #(
   parameter int DEPTH = 8,
   parameter int WORD_WIDTH = 32,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input logic        clock,
   input logic        reset,
   orb_req_if.sink    req_ch,
   orb_rsp_if.source  rsp_ch
);

   orb_pkg::enq_type            enq;
   logic [orb_pkg::Q_LVL_W-1:0] q_level;
   logic                        ram_wr_en;
   logic [PTR_W-1:0]            ram_wr_addr;
   logic [WORD_WIDTH-1:0]       ram_wr_data;
   logic                        ram_rd_en;
   logic [PTR_W-1:0]            ram_rd_addr;
   logic [WORD_WIDTH-1:0]       ram_rd_data;

   // Entry storage.
   orb_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Request side: pointers, count and classification.
   orb_front #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .q_level     (q_level),
      .enq         (enq),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // Response side: result queue and output register.
   orb_back u_back (
      .clock   (clock),
      .reset   (reset),
      .enq     (enq),
      .q_level (q_level),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ===== tb/orb_checker.sv =====
// Response checker for the overwriting ring buffer: watches both channels, keeps its own
// copy of the ring contents and compares every response word field by field.
// Depends on orb_pkg and the channel interfaces in orb_if.
module orb_checker #(
   parameter int DEPTH = 8
) (
   input  logic clock,
   input  logic reset,
   orb_req_if   req_ch,
   orb_rsp_if   rsp_ch,
   output int   error_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Shadow of the ring: stored words, oldest and next-write positions, fill level.
   logic [orb_pkg::DATA_W-1:0] ring_words [DEPTH];
   logic [IDX_W-1:0]           oldest_idx;
   logic [IDX_W-1:0]           write_idx;
   int unsigned                fill_level;

   // Responses owed by the block, oldest first.
   orb_pkg::cmd_type due_answers [$];

   // Step a ring position forward, wrapping at the ring depth.
   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   // Apply one request to the shadow ring and return the response it must produce.
   function automatic orb_pkg::cmd_type apply_request(
      input logic [1:0] kind, input logic [orb_pkg::DATA_W-1:0] word);
      orb_pkg::cmd_type answer;
      answer = '0;
      case (kind)
         orb_pkg::REQ_PUSH: begin
            ring_words[write_idx] = word;
            write_idx = next_idx(write_idx);
            // A push into a full ring drops the oldest word and keeps the level.
            if (fill_level < DEPTH) begin
               fill_level++;
            end else begin
               oldest_idx = next_idx(oldest_idx);
               answer.overwrote_oldest = 1'b1;
            end
         end
         orb_pkg::REQ_POP, orb_pkg::REQ_PEEK: begin
            if (fill_level == 0) begin
               answer.underflow = 1'b1;
            end else begin
               answer.read_value = ring_words[oldest_idx];
               if (kind == orb_pkg::REQ_POP) begin
                  oldest_idx = next_idx(oldest_idx);
                  fill_level--;
               end
            end
         end
         // An unknown kind leaves the ring alone and only reports its status.
         default: begin
         end
      endcase
      answer.item_count = orb_pkg::COUNT_W'(fill_level);
      answer.is_empty   = (fill_level == 0);
      answer.is_full    = (fill_level == DEPTH);
      return answer;
   endfunction

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what, input logic [orb_pkg::DATA_W-1:0] got,
                                  input logic [orb_pkg::DATA_W-1:0] want);
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // Sample both handshakes at the rising edge; responses are checked before the
   // request of the same edge is predicted, since a response never belongs to it.
   always @(posedge clock) begin
      orb_pkg::cmd_type want;
      if (reset) begin
         oldest_idx = '0;
         write_idx  = '0;
         fill_level = 0;
         due_answers.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_answers.size() == 0) begin
               report_mismatch("unexpected response word", rsp_ch.read_value, '0);
            end else begin
               want = due_answers.pop_front();
               if (rsp_ch.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_ch.read_value, want.read_value);
               if (rsp_ch.underflow !== want.underflow)
                  report_mismatch("underflow", orb_pkg::DATA_W'(rsp_ch.underflow),
                                  orb_pkg::DATA_W'(want.underflow));
               if (rsp_ch.overwrote_oldest !== want.overwrote_oldest)
                  report_mismatch("overwrote_oldest",
                                  orb_pkg::DATA_W'(rsp_ch.overwrote_oldest),
                                  orb_pkg::DATA_W'(want.overwrote_oldest));
               if (rsp_ch.item_count !== want.item_count)
                  report_mismatch("item_count", orb_pkg::DATA_W'(rsp_ch.item_count),
                                  orb_pkg::DATA_W'(want.item_count));
               if (rsp_ch.is_empty !== want.is_empty)
                  report_mismatch("is_empty", orb_pkg::DATA_W'(rsp_ch.is_empty),
                                  orb_pkg::DATA_W'(want.is_empty));
               if (rsp_ch.is_full !== want.is_full)
                  report_mismatch("is_full", orb_pkg::DATA_W'(rsp_ch.is_full),
                                  orb_pkg::DATA_W'(want.is_full));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            due_answers.push_back(apply_request(req_ch.req_type, req_ch.push_value));
         end
      end
      pending_count = due_answers.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the ring buffer testbench: clock, reset, request stimulus, response stalls,
// a watchdog on handshake progress and the final verdict.
// Depends on orb_pkg, orb_if, the overwriting_ring_buffer_top design and orb_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         RING_DEPTH  = 8;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int         ITEM_GOAL   = 850;
   localparam int         LONG_HOLD   = 200;
   localparam int         IDLE_LIMIT  = 2000;
   localparam int         SETTLE      = 8;

   // Response-side stall styles.
   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   hold_rsp = 1'b0;
   int   mismatches;
   int   awaiting;

   orb_req_if req_ch ();
   orb_rsp_if rsp_ch ();

   overwriting_ring_buffer_top #(
      .DEPTH(RING_DEPTH),
      .WORD_WIDTH(orb_pkg::DATA_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   orb_checker #(
      .DEPTH(RING_DEPTH)
   ) ring_check (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .error_count(mismatches),
      .pending_count(awaiting)
   );

   // Free-running clock, 4 ns period.
   initial begin
      forever #2 clock = ~clock;
   end

   // Offer one request word from a falling edge and hold it until it is taken.
   task automatic send_word(input logic [1:0] kind, input logic [orb_pkg::DATA_W-1:0] word);
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.push_value <= word;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Leave the request channel idle for a number of cycles.
   task automatic idle_gap(input int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Stop offering and wait until every owed response word has come back.
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
   endtask

   // Response stalls: one of four stall styles, redrawn at random, plus one long hold on request.
   initial begin : rsp_stall_pattern
      int          cyc;
      rx_mode_type mode;
      rsp_ch.ready = 1'b0;
      cyc = 0;
      mode = RX_OPEN;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
         end
         if (cyc % 64 == 0) mode = rx_mode_type'($urandom_range(0, 3));
         case (mode)
            RX_OPEN:     rsp_ch.ready <= 1'b1;
            RX_LIGHT:    rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            RX_HEAVY:    rsp_ch.ready <= ($urandom_range(0, 9) < 3);
            RX_PERIODIC: rsp_ch.ready <= ((cyc % 5) >= 2);
            default:     rsp_ch.ready <= 1'b1;
         endcase
         cyc++;
      end
   end

   // Watchdog: end the run when no word moves on either channel for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Request stimulus and verdict.
   initial begin : stimulus
      int                         sent;
      int                         burst;
      int                         push_pct;
      int                         phase_left;
      bit                         streaming;
      logic [1:0]                 kind;
      logic [orb_pkg::DATA_W-1:0] word;

      req_ch.valid      = 1'b0;
      req_ch.req_type   = orb_pkg::REQ_PUSH;
      req_ch.push_value = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reads of an empty ring, an unknown kind, fill past full, then drain.
      send_word(orb_pkg::REQ_POP, '0);
      send_word(orb_pkg::REQ_PEEK, 32'hFFFF_FFFF);
      send_word(REQ_UNKNOWN, 32'h1234_5678);
      send_word(orb_pkg::REQ_PUSH, 32'h0000_0000);
      send_word(orb_pkg::REQ_PUSH, 32'hFFFF_FFFF);
      send_word(orb_pkg::REQ_PUSH, 32'hAAAA_AAAA);
      send_word(orb_pkg::REQ_PUSH, 32'h5555_5555);
      send_word(orb_pkg::REQ_PUSH, 32'h0000_0001);
      send_word(orb_pkg::REQ_PUSH, 32'h8000_0000);
      send_word(orb_pkg::REQ_PUSH, 32'h7FFF_FFFF);
      send_word(orb_pkg::REQ_PUSH, 32'hFFFF_FFFE);
      send_word(orb_pkg::REQ_PUSH, 32'hDEAD_BEEF);
      send_word(orb_pkg::REQ_PUSH, 32'h0F0F_0F0F);
      send_word(orb_pkg::REQ_PEEK, '0);
      send_word(REQ_UNKNOWN, 32'hFFFF_FFFF);
      repeat (RING_DEPTH) send_word(orb_pkg::REQ_POP, '0);
      send_word(orb_pkg::REQ_POP, '0);
      wait_for_drain();

      // Long response hold while pushes keep coming, so the block backs up.
      hold_rsp = 1'b1;
      repeat (24) send_word(orb_pkg::REQ_PUSH, $urandom);
      wait_for_drain();

      // Random phases that lean toward filling, balancing or draining the ring.
      sent = 0;
      phase_left = 0;
      push_pct = 50;
      streaming = 1'b0;
      while (sent < ITEM_GOAL) begin
         if (phase_left <= 0) begin
            phase_left = $urandom_range(40, 120);
            case ($urandom_range(0, 2))
               0:       push_pct = 80;
               1:       push_pct = 50;
               default: push_pct = 25;
            endcase
            streaming = ($urandom_range(0, 2) == 0);
         end
         burst = $urandom_range(1, 16);
         repeat (burst) begin
            if ($urandom_range(0, 99) < 3) begin
               kind = REQ_UNKNOWN;
            end else if ($urandom_range(0, 99) < push_pct) begin
               kind = orb_pkg::REQ_PUSH;
            end else if ($urandom_range(0, 3) == 0) begin
               kind = orb_pkg::REQ_PEEK;
            end else begin
               kind = orb_pkg::REQ_POP;
            end
            case ($urandom_range(0, 7))
               0:       word = '0;
               1:       word = '1;
               2:       word = orb_pkg::DATA_W'($urandom_range(0, 15));
               default: word = $urandom;
            endcase
            send_word(kind, word);
            if (kind != REQ_UNKNOWN) begin
               sent++;
               phase_left--;
            end
         end
         if ($urandom_range(0, 39) == 0) begin
            wait_for_drain();
         end else if (!streaming && $urandom_range(0, 3) != 0) begin
            idle_gap($urandom_range(1, 6));
         end
      end

      // Let every owed response arrive, then allow for any stray word.
      wait_for_drain();
      repeat (SETTLE) @(negedge clock);
      if (mismatches == 0 && awaiting == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
